/* src/bba_pkg.sv */
// bba_pkg: shared constants, command codes and helpers of the bitmap block allocator
// depends on nothing; used by the interfaces, by bitmap_block_allocator and by the sim modules
package bba_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 65536;
    localparam int BLOCKS_PER_MAP_CLUSTER = 2048 * 8;

    localparam int CMD_W = 2;
    localparam int BLK_W = 16;
    localparam int LIM_W = 17;
    localparam int CNT_W = 14;
    localparam int BYTE_W = 8;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] TOP_BIT   = 8'h80;
    localparam logic [LIM_W-1:0] NUM_BLOCKS_RESET = 17'h10000;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [BLK_W-1:0]  blk_t;
    typedef logic [LIM_W-1:0]  lim_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // position of the leftmost clear bit, msb counted as 0
    function automatic logic [2:0] first_clear(input byte_t value);
        logic [2:0] k;
        k = 3'd0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (!value[i])
            begin
                k = 3'(BYTE_W - 1 - i);
            end
        end
        return k;
    endfunction

endpackage

/* src/bba_ifs.sv */
// bba_ifs: request, response and configuration channels of the allocator
// depends on bba_pkg for field types
interface bba_req_if;
    logic                   valid;
    logic                   ready;
    logic [bba_pkg::CMD_W-1:0] command;
    bba_pkg::blk_t          block_number;

    modport source (output valid, command, block_number, input ready);
    modport sink   (input valid, command, block_number, output ready);
endinterface

interface bba_rsp_if;
    logic          valid;
    logic          ready;
    bba_pkg::blk_t allocated_block;
    logic          success;

    modport source (output valid, allocated_block, success, input ready);
    modport sink   (input valid, allocated_block, success, output ready);
endinterface

interface bba_cfg_if;
    logic          valid;
    logic          ready;
    bba_pkg::lim_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* src/bitmap_block_allocator.sv */
// bitmap_block_allocator: first-fit free-space bitmap allocator over one byte-wide ram
// depends on bba_pkg, bba_ifs and bba_ram
// one request at a time; the next can be accepted in the same cycle as the response turns valid
// allocate scans the covered bytes in order until one has a clear bit; free reads then rewrites one byte;
// format writes every covered byte; an empty partition, a refused free and other codes answer directly
// reset: clearing pass writes zero to all (MAX_BLOCKS+7)/8 bytes, one per cycle, then idle
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bba_req_if.sink      req,
    bba_rsp_if.source    rsp,
    bba_cfg_if.sink      cfg
);

    localparam int DEPTH = (MAX_BLOCKS + 7) / 8;
    localparam int AW = $clog2(DEPTH);
    localparam int LIM_CAP_INT = (MAX_BLOCKS < 65536) ? MAX_BLOCKS : 65536;
    localparam bba_pkg::lim_t LIM_CAP = bba_pkg::LIM_W'(LIM_CAP_INT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_FREE_RD = 3'd3;
    localparam logic [2:0] ST_FREE_WR = 3'd4;
    localparam logic [2:0] ST_FORMAT  = 3'd5;
    localparam logic [2:0] ST_RESP    = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            dv_reg, dv_next;
    bba_pkg::lim_t   num_blocks_reg;
    logic            out_valid_reg, out_valid_next;
    bba_pkg::blk_t   out_block_reg, out_block_next;
    logic            out_ok_reg, out_ok_next;
    bba_pkg::blk_t   blk_reg, blk_next;
    bba_pkg::cnt_t   iss_reg, iss_next;
    bba_pkg::cnt_t   daddr_reg, daddr_next;
    bba_pkg::blk_t   res_block_reg, res_block_next;
    logic            res_ok_reg, res_ok_next;

    bba_pkg::lim_t   limit;
    bba_pkg::lim_t   lim_plus;
    bba_pkg::lim_t   lim_rsv;
    bba_pkg::cnt_t   nbytes;
    logic [2:0]      reserved;
    bba_pkg::byte_t  fmt_byte0;
    logic [2:0]      k;
    bba_pkg::lim_t   cand;
    logic            blk_fits;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    bba_pkg::byte_t  mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    bba_pkg::byte_t  mem_rdata;

    bba_ram #(
        .WIDTH (bba_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // effective block count and derived sizes
    assign limit     = (num_blocks_reg > LIM_CAP) ? LIM_CAP : num_blocks_reg;
    assign lim_plus  = limit + bba_pkg::LIM_W'(7);
    assign nbytes    = lim_plus[bba_pkg::LIM_W-1:3];
    assign lim_rsv   = limit + bba_pkg::LIM_W'(bba_pkg::BLOCKS_PER_MAP_CLUSTER - 1);
    assign reserved  = lim_rsv[bba_pkg::LIM_W-1:14] + 3'd1;
    assign fmt_byte0 = ~(bba_pkg::FULL_BYTE >> reserved);
    assign k         = bba_pkg::first_clear(mem_rdata);
    assign cand      = {daddr_reg, k};
    assign blk_fits  = {1'b0, req.block_number} < limit;

    assign req.ready           = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign rsp.valid           = out_valid_reg;
    assign rsp.allocated_block = out_block_reg;
    assign rsp.success         = out_ok_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        dv_next        = dv_reg;
        out_valid_next = out_valid_reg;
        out_block_next = out_block_reg;
        out_ok_next    = out_ok_reg;
        blk_next       = blk_reg;
        iss_next       = iss_reg;
        daddr_next     = daddr_reg;
        res_block_next = res_block_reg;
        res_ok_next    = res_ok_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    blk_next       = req.block_number;
                    iss_next       = '0;
                    dv_next        = 1'b0;
                    res_block_next = '0;
                    res_ok_next    = 1'b0;
                    case (req.command)
                        bba_pkg::CMD_ALLOC:
                        begin
                            state_next = (nbytes == '0) ? ST_RESP : ST_SCAN;
                        end
                        bba_pkg::CMD_FREE:
                        begin
                            state_next = blk_fits ? ST_FREE_RD : ST_RESP;
                        end
                        bba_pkg::CMD_FORMAT:
                        begin
                            res_ok_next = 1'b1;
                            state_next  = (nbytes == '0) ? ST_RESP : ST_FORMAT;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // reads run one byte ahead of the check
                if (iss_reg < nbytes)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(iss_reg);
                    iss_next   = iss_reg + bba_pkg::CNT_W'(1);
                    dv_next    = 1'b1;
                    daddr_next = iss_reg;
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg)
                begin
                    if (mem_rdata != bba_pkg::FULL_BYTE)
                    begin
                        state_next = ST_RESP;
                        if (cand < limit)
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = AW'(daddr_reg);
                            mem_wdata      = mem_rdata | (bba_pkg::TOP_BIT >> k);
                            res_block_next = cand[bba_pkg::BLK_W-1:0];
                            res_ok_next    = 1'b1;
                        end
                    end
                    else if (daddr_reg == nbytes - bba_pkg::CNT_W'(1))
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_FREE_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(blk_reg[bba_pkg::BLK_W-1:3]);
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(blk_reg[bba_pkg::BLK_W-1:3]);
                mem_wdata   = mem_rdata & ~(bba_pkg::TOP_BIT >> blk_reg[2:0]);
                res_ok_next = 1'b1;
                state_next  = ST_RESP;
            end
            ST_FORMAT:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(iss_reg);
                mem_wdata = (iss_reg == '0) ? fmt_byte0 : '0;
                iss_next  = iss_reg + bba_pkg::CNT_W'(1);
                if (iss_reg == nbytes - bba_pkg::CNT_W'(1))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_block_next = res_block_reg;
                    out_ok_next    = res_ok_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            dv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            num_blocks_reg <= bba_pkg::NUM_BLOCKS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                num_blocks_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_block_reg <= out_block_next;
        out_ok_reg    <= out_ok_next;
        blk_reg       <= blk_next;
        iss_reg       <= iss_next;
        daddr_reg     <= daddr_next;
        res_block_reg <= res_block_next;
        res_ok_reg    <= res_ok_next;
    end

    // idle never touches the bitmap
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("bitmap written while idle");

    // a nonzero grant always reports success
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_block_reg != '0) |-> out_ok_reg)
        else $error("nonzero block without success");

    // an accepted request leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != ST_IDLE))
        else $error("request accepted but still idle");

    // command writes stay inside the covered bytes
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg == ST_FORMAT || state_reg == ST_SCAN))
            |-> ({{(bba_pkg::CNT_W + 1){1'b0}}, mem_waddr} < {{(AW + 1){1'b0}}, nbytes}))
        else $error("bitmap write beyond covered bytes");

endmodule

/* src/bba_ram.sv */
// bba_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sim/bitmap_block_allocator_checker.sv */
`timescale 1ns / 100ps
// bitmap_block_allocator_checker: watches the request, response and configuration channels,
// keeps its own copy of the usage bitmap and compares every response with the predicted one
// depends on bba_pkg and the channel interfaces in bba_ifs
module bitmap_block_allocator_checker #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    bba_req_if   req,
    bba_rsp_if   rsp,
    bba_cfg_if   cfg,
    output int   error_count,
    output int   pending
);
    import bba_pkg::*;

    localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;

    typedef struct packed {
        blk_t allocated_block;
        logic success;
    } grant_t;

    byte_t  usage_map [MAP_BYTES];
    lim_t   num_blocks_q;
    grant_t expected_grants [$];

    task automatic run_command(input logic [CMD_W-1:0] cmd, input blk_t blk, output grant_t res);
        int lim;
        int nbytes;
        int reserved;
        int k;
        int b;
        byte_t v;
        lim = num_blocks_q;
        if (lim > MAX_BLOCKS)
        begin
            lim = MAX_BLOCKS;
        end
        if (lim > 65536)
        begin
            lim = 65536;
        end
        nbytes = (lim + 7) / 8;
        if (nbytes > MAP_BYTES)
        begin
            nbytes = MAP_BYTES;
        end
        res = '0;
        case (cmd)
            CMD_ALLOC:
            begin
                for (int i = 0; i < nbytes; i++)
                begin
                    if (usage_map[i] != FULL_BYTE)
                    begin
                        k = 0;
                        while (usage_map[i][7 - k])
                        begin
                            k++;
                        end
                        b = i * 8 + k;
                        // first clear bit past the partition counts as full
                        if (b < lim)
                        begin
                            usage_map[i][7 - k] = 1'b1;
                            res.allocated_block = blk_t'(b);
                            res.success = 1'b1;
                        end
                        break;
                    end
                end
            end
            CMD_FREE:
            begin
                if (int'(blk) < lim)
                begin
                    if (int'(blk) / 8 < MAP_BYTES)
                    begin
                        usage_map[int'(blk) / 8][7 - int'(blk) % 8] = 1'b0;
                    end
                    res.success = 1'b1;
                end
            end
            CMD_FORMAT:
            begin
                reserved = (lim + BLOCKS_PER_MAP_CLUSTER - 1) / BLOCKS_PER_MAP_CLUSTER + 1;
                for (int i = 0; i < nbytes; i++)
                begin
                    v = '0;
                    for (int j = 0; j < 8; j++)
                    begin
                        if (i * 8 + j < reserved)
                        begin
                            v[7 - j] = 1'b1;
                        end
                    end
                    usage_map[i] = v;
                end
                res.success = 1'b1;
            end
            default:
            begin
                res = '0;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        grant_t predicted;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            foreach (usage_map[i])
            begin
                usage_map[i] = '0;
            end
            num_blocks_q = NUM_BLOCKS_RESET;
            expected_grants.delete();
            error_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("response with no request outstanding: allocated_block %0d success %0d",
                           rsp.allocated_block, rsp.success);
                    errs++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp.allocated_block !== want.allocated_block)
                    begin
                        $error("allocated_block: expected %0d, got %0d",
                               want.allocated_block, rsp.allocated_block);
                        errs++;
                    end
                    if (rsp.success !== want.success)
                    begin
                        $error("success: expected %0d, got %0d", want.success, rsp.success);
                        errs++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                num_blocks_q = cfg.data;
            end
            if (req.valid && req.ready)
            begin
                run_command(req.command, req.block_number, predicted);
                expected_grants = {expected_grants, predicted};
            end
            error_count <= error_count + errs;
            pending <= expected_grants.size();
        end
    end

endmodule

/* sim/bitmap_block_allocator_tb.sv */
`timescale 1ns / 100ps
// bitmap_block_allocator_tb: drives directed and random allocate, free, format and unused-code requests
// across several partition sizes; the checker beside the block predicts and compares
// depends on bba_pkg, bba_ifs, bitmap_block_allocator and bitmap_block_allocator_checker
module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_BLOCKS = MAX_BLOCKS_DEFAULT;
    localparam int SEGMENTS = 12;
    localparam int ITEMS_PER_SEGMENT = 6;
    localparam longint TIMEOUT_NS = 64'd60_000_000;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   error_count;
    int   pending;
    int   cur_limit;

    bba_req_if req_ch();
    bba_rsp_if rsp_ch();
    bba_cfg_if cfg_ch();

    bitmap_block_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bitmap_block_allocator_checker #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic issue_command(input logic [CMD_W-1:0] cmd, input blk_t blk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.command <= cmd;
        req_ch.block_number <= blk;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // the checker count is registered, so wait for a clock edge before looking at it
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_num_blocks(input lim_t value);
        wait_all_answered();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_limit = value;
        if (cur_limit > MAX_BLOCKS)
        begin
            cur_limit = MAX_BLOCKS;
        end
        if (cur_limit > 65536)
        begin
            cur_limit = 65536;
        end
    endtask

    // mostly allocate and free of low blocks, usually after a format, some noise on top
    task automatic run_alloc_mix(input lim_t value, input int count);
        int roll;
        int alloc_pct;
        int span;
        set_num_blocks(value);
        if ($urandom_range(0, 3) != 0)
        begin
            issue_command(CMD_FORMAT, blk_t'($urandom));
        end
        alloc_pct = (cur_limit <= 64) ? 70 : 55;
        span = (cur_limit < 64) ? cur_limit : 64;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2 && $urandom_range(0, 3) == 0)
            begin
                wait_all_answered();
            end
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
            begin
                issue_command(CMD_ALLOC, blk_t'($urandom));
            end
            else if (roll < alloc_pct + 20)
            begin
                if (span == 0)
                begin
                    issue_command(CMD_FREE, blk_t'($urandom));
                end
                else
                begin
                    issue_command(CMD_FREE, blk_t'($urandom_range(0, span - 1)));
                end
            end
            else if (roll < alloc_pct + 25)
            begin
                issue_command(CMD_FREE, blk_t'($urandom));
            end
            else if (roll < alloc_pct + 28)
            begin
                issue_command(CMD_UNUSED, blk_t'($urandom));
            end
            else
            begin
                issue_command(CMD_FORMAT, blk_t'($urandom));
            end
        end
    endtask

    initial
    begin : stimulus
        lim_t plan [SEGMENTS] = '{17'd16, 17'd8, 17'd65536, 17'd0, 17'd7, 17'h1FFFF,
                                  17'd64, 17'd17, 17'd100, 17'd65537, 17'd1, 17'd40};
        src_idle_pct = 27;
        sink_idle_pct = 50;
        cur_limit = 65536;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_ALLOC;
        req_ch.block_number = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // unformatted bitmap at reset size, then a format
        issue_command(CMD_ALLOC, '0);
        issue_command(CMD_ALLOC, '0);
        issue_command(CMD_FREE, 16'd0);
        issue_command(CMD_FREE, 16'd0);
        issue_command(CMD_FREE, 16'hFFFF);
        issue_command(CMD_UNUSED, 16'hFFFF);
        issue_command(CMD_ALLOC, 16'hFFFF);
        issue_command(CMD_FORMAT, 16'hFFFF);
        issue_command(CMD_ALLOC, '0);

        // partition end inside a byte
        set_num_blocks(17'd10);
        issue_command(CMD_FORMAT, '0);
        repeat (9) issue_command(CMD_ALLOC, '0);
        issue_command(CMD_FREE, 16'd10);
        issue_command(CMD_FREE, 16'd9);
        issue_command(CMD_ALLOC, '0);

        // empty partition
        set_num_blocks(17'd0);
        issue_command(CMD_ALLOC, '0);
        issue_command(CMD_FREE, 16'd0);
        issue_command(CMD_FORMAT, '0);

        for (int s = 0; s < SEGMENTS; s++)
        begin
            if (s == 4)
            begin
                src_idle_pct = 50;
                sink_idle_pct = 27;
            end
            else if (s == 8)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            run_alloc_mix(plan[s], ITEMS_PER_SEGMENT);
        end

        wait_all_answered();
        repeat (16) @(posedge clk);
        if (error_count == 0 && pending == 0)
        begin
            $display("bitmap_block_allocator_tb: clean");
        end
        else
        begin
            $display("bitmap_block_allocator_tb: errors");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("bitmap_block_allocator_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
src/bba_pkg.sv
src/bba_ifs.sv
src/bba_ram.sv
src/bitmap_block_allocator.sv
sim/bitmap_block_allocator_checker.sv
sim/bitmap_block_allocator_tb.sv
